>>> rtl/sliding_window_peak_detector_assert.svh
// ----------------------------------------------------------------------------
// Sliding window peak detector: assertion macros
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_PEAK_DETECTOR_ASSERT_SVH
`define SLIDING_WINDOW_PEAK_DETECTOR_ASSERT_SVH

// Same-cycle implication.
`define SWPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SWPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/swpd_pkg.sv
// ----------------------------------------------------------------------------
// swpd_pkg
// Widths, window geometry and shared types of the sliding window peak detector.
// ----------------------------------------------------------------------------
package swpd_pkg;

    localparam int WINDOW_SIZE     = 11;
    localparam int CENTRE_POSITION = 5;
    localparam int SAMPLE_WIDTH    = 16;
    localparam int INDEX_WIDTH     = 16;
    localparam int DELAY_DEPTH     = CENTRE_POSITION + 1;
    localparam int CNT_WIDTH       = 16;

    localparam logic [CNT_WIDTH-1:0] FRAME_LENGTH_RESET = CNT_WIDTH'(4096);

    typedef logic signed [SAMPLE_WIDTH-1:0] swpd_sample_t;
    typedef logic [INDEX_WIDTH-1:0]         swpd_index_t;
    typedef logic [CNT_WIDTH-1:0]           swpd_count_t;

    typedef struct packed {
        logic        hit;
        swpd_index_t index;
    } swpd_stage_t;

endpackage

>>> rtl/swpd_sample_if.sv
// ----------------------------------------------------------------------------
// swpd_sample_if
// Sample request channel: correlation and threshold samples.
// ----------------------------------------------------------------------------
interface swpd_sample_if
    import swpd_pkg::*;
();
    logic         valid;
    logic         ready;
    swpd_sample_t corr_sample;
    swpd_sample_t threshold_sample;

    modport source (output valid, output corr_sample, output threshold_sample, input ready);
    modport sink   (input valid, input corr_sample, input threshold_sample, output ready);
endinterface

>>> rtl/swpd_peak_if.sv
// ----------------------------------------------------------------------------
// swpd_peak_if
// Result channel: frame position of each detected peak.
// ----------------------------------------------------------------------------
interface swpd_peak_if
    import swpd_pkg::*;
();
    logic        valid;
    logic        ready;
    swpd_index_t peak_index;

    modport source (output valid, output peak_index, input ready);
    modport sink   (input valid, input peak_index, output ready);
endinterface

>>> rtl/swpd_cfg_if.sv
// ----------------------------------------------------------------------------
// swpd_cfg_if
// Configuration write channel carrying the frame length.
// ----------------------------------------------------------------------------
interface swpd_cfg_if
    import swpd_pkg::*;
();
    logic        valid;
    logic        ready;
    swpd_count_t frame_length;

    modport source (output valid, output frame_length, input ready);
    modport sink   (input valid, input frame_length, output ready);
endinterface

>>> rtl/sliding_window_peak_detector.sv
// ----------------------------------------------------------------------------
// sliding_window_peak_detector
// Local-maximum peak detector over a sliding sample window, per frame.
//
//   channel    dir   handshake      payload
//   sample_in  in    valid/ready    corr_sample, threshold_sample
//   peak_out   out   valid/ready    peak_index
//   cfg        in    valid/ready    frame_length
//
// One sample request per cycle while sample_in.ready is high; a peak leaves from the result register.
// Window register stage, then result register; the peak test sits between.
// Reset clears the frame counter and both valid flags; frame_length is 4096.
// sample_in.ready falls only while a peak waits in a held result register.
// cfg.ready is always high.
// ----------------------------------------------------------------------------
module sliding_window_peak_detector
    import swpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    swpd_sample_if.sink sample_in,
    swpd_peak_if.source peak_out,
    swpd_cfg_if.sink    cfg
);

    swpd_count_t       frame_length_reg;
    swpd_count_t       count_reg;
    swpd_count_t       count_next;
    logic [CNT_WIDTH:0] count_inc;
    logic              advance;
    logic              push;
    swpd_stage_t       stage;

    assign cfg.ready       = 1'b1;
    assign sample_in.ready = advance;
    assign push            = sample_in.valid && advance;
    assign count_inc       = {1'b0, count_reg} + (CNT_WIDTH+1)'(1);

    always_comb
    begin
        count_next = count_reg;
        if (push)
        begin
            if (count_inc >= {1'b0, frame_length_reg})
            begin
                count_next = '0;
            end
            else
            begin
                count_next = count_inc[CNT_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            frame_length_reg <= FRAME_LENGTH_RESET;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg.valid)
            begin
                frame_length_reg <= cfg.frame_length;
            end
        end
    end

    swpd_window u_window (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .advance          (advance),
        .corr_sample      (sample_in.corr_sample),
        .threshold_sample (sample_in.threshold_sample),
        .pos              (count_reg),
        .stage            (stage)
    );

    swpd_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .stage    (stage),
        .advance  (advance),
        .peak_out (peak_out)
    );

endmodule

>>> rtl/swpd_window.sv
// ----------------------------------------------------------------------------
// swpd_window
// Sample window and threshold delay line with the centre peak test.
// ----------------------------------------------------------------------------
module swpd_window
    import swpd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic         advance,
    input  swpd_sample_t corr_sample,
    input  swpd_sample_t threshold_sample,
    input  swpd_count_t  pos,
    output swpd_stage_t  stage
);

    swpd_sample_t win_reg [WINDOW_SIZE];
    swpd_sample_t thr_reg [DELAY_DEPTH];
    logic         full_reg;
    swpd_index_t  index_reg;
    logic         valid_reg;
    logic         valid_next;
    logic         peak;
    swpd_sample_t centre;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            win_reg[0] <= corr_sample;
            for (int k = 1; k < WINDOW_SIZE; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
            thr_reg[0] <= threshold_sample;
            for (int k = 1; k < DELAY_DEPTH; k++)
            begin
                thr_reg[k] <= thr_reg[k-1];
            end
            full_reg  <= (pos >= CNT_WIDTH'(WINDOW_SIZE - 1));
            index_reg <= INDEX_WIDTH'(pos - CNT_WIDTH'(CENTRE_POSITION));
        end
    end

    always_comb
    begin
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        centre = win_reg[CENTRE_POSITION];
        peak   = valid_reg && full_reg && (centre > thr_reg[CENTRE_POSITION]);
        for (int k = 0; k < WINDOW_SIZE; k++)
        begin
            if (k != CENTRE_POSITION && win_reg[k] > centre)
            begin
                peak = 1'b0;
            end
        end
    end

    assign stage.hit   = peak;
    assign stage.index = index_reg;

endmodule

>>> rtl/swpd_out_stage.sv
// ----------------------------------------------------------------------------
// swpd_out_stage
// Result register and stall control towards the result channel.
// ----------------------------------------------------------------------------
module swpd_out_stage
    import swpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  swpd_stage_t        stage,
    output logic               advance,
    swpd_peak_if.source        peak_out
);

    logic        valid_reg;
    logic        valid_next;
    swpd_index_t index_reg;
    logic        load;

    assign advance = !(stage.hit && valid_reg && !peak_out.ready);
    assign load    = stage.hit && advance;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (peak_out.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            index_reg <= stage.index;
        end
    end

    assign peak_out.valid      = valid_reg;
    assign peak_out.peak_index = index_reg;

endmodule

>>> rtl/swpd_checker.sv
// ----------------------------------------------------------------------------
// swpd_checker
// Port-level checks on the peak detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "sliding_window_peak_detector_assert.svh"

module swpd_checker
    import swpd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input swpd_index_t peak_index
);

    `SWPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(peak_index), "held peak request changed")
    `SWPD_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready, "sample request stalled without output back-pressure")
    `SWPD_ASSERT_NOW(a_peak_origin, $rose(out_valid), $past(in_valid && in_ready, 2), "peak request without sample two cycles earlier")

endmodule

bind sliding_window_peak_detector swpd_checker u_swpd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample_in.valid),
    .in_ready   (sample_in.ready),
    .out_valid  (peak_out.valid),
    .out_ready  (peak_out.ready),
    .peak_index (peak_out.peak_index)
);
